### design/mcwd_pkg.sv
// ----------------------------------------------------------------------------
// Microcode control word decoder package
// Control line masks, constant-select codes and opcode values for the
// decoder; the top level uses only the widths.
// ----------------------------------------------------------------------------
package mcwd_pkg;

	localparam int unsigned OP_W   = 8;
	localparam int unsigned STEP_W = 4;
	localparam int unsigned FLAG_W = 4;
	localparam int unsigned WORD_W = 16;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [WORD_W:0]   lookup_t;

	// Control lines, positive logic before inversion.
	localparam word_t K_GPI   = 16'h0002;
	localparam word_t K_GPO   = 16'h0010;
	localparam word_t K_LDC   = 16'h0020;
	localparam word_t K_LDTF  = 16'h0040;
	localparam word_t K_LDS   = 16'h0080;
	localparam word_t K_LDRH  = 16'h0100;
	localparam word_t K_OEMEM = 16'h0200;
	localparam word_t K_OET   = 16'h0400;
	localparam word_t K_LDT   = 16'h0800;
	localparam word_t K_LDMEM = 16'h1000;
	localparam word_t K_LDRL  = 16'h2000;
	localparam word_t K_INCR  = 16'h4000;
	localparam word_t K_OEALU = 16'h8000;
	localparam word_t K_FETCH = K_OEMEM | 16'h0001 | K_INCR;
	localparam word_t K_INVERT = 16'hA7F0;

	// Constant-select codes.
	localparam logic [3:0] Q_NEG  = 4'd8;
	localparam logic [3:0] Q_MEM  = 4'd0;
	localparam logic [3:0] Q_NAND = 4'd1;
	localparam logic [3:0] Q_ADD  = 4'd2;
	localparam logic [3:0] Q_ADDF = 4'd3;
	localparam logic [3:0] Q_FF   = 4'd4;
	localparam logic [3:0] Q_B    = 4'd4;
	localparam logic [3:0] Q_A    = 4'd5;
	localparam logic [3:0] Q_UN   = 4'd5;
	localparam logic [3:0] Q_RH   = 4'd6;
	localparam logic [3:0] Q_RL   = 4'd7;
	localparam logic [3:0] Q_GPO_IDLE  = 4'hF;
	localparam logic [3:0] Q_GPO_LOW   = 4'hE;
	localparam logic [3:0] Q_GPO_BREAK = 4'hD;

	// Opcodes.
	localparam logic [OP_W-1:0] OP_NOP      = 8'h00;
	localparam logic [OP_W-1:0] OP_STORE    = 8'h01;
	localparam logic [OP_W-1:0] OP_LDA_ABS  = 8'h02;
	localparam logic [OP_W-1:0] OP_LDB_ABS  = 8'h03;
	localparam logic [OP_W-1:0] OP_LDA_IND  = 8'h04;
	localparam logic [OP_W-1:0] OP_LDB_IND  = 8'h05;
	localparam logic [OP_W-1:0] OP_TX_A     = 8'h0F;
	localparam logic [OP_W-1:0] OP_TX_IMM   = 8'h10;
	localparam logic [OP_W-1:0] OP_TX_MEM   = 8'h11;
	localparam logic [OP_W-1:0] OP_TX_STOP  = 8'h12;
	localparam logic [OP_W-1:0] OP_TX_BREAK = 8'h20;
	localparam logic [OP_W-1:0] OP_RX_WAIT  = 8'h21;
	localparam logic [OP_W-1:0] OP_RX_FIRST = 8'h22;
	localparam logic [OP_W-1:0] OP_RX_BIT   = 8'h23;
	localparam logic [OP_W-1:0] OP_RX_LAST  = 8'h24;
	localparam logic [OP_W-1:0] OP_INC      = 8'h70;
	localparam logic [OP_W-1:0] OP_CMP      = 8'h71;
	localparam logic [OP_W-1:0] OP_JMP      = 8'h80;
	localparam logic [OP_W-1:0] OP_JC       = 8'h81;
	localparam logic [OP_W-1:0] OP_JNZ      = 8'h84;

	localparam lookup_t L_MISS = 17'h10000;

	function automatic word_t cst(input logic [3:0] c);
		return {12'h000, c} | K_LDC;
	endfunction

	function automatic lookup_t hit(input word_t w);
		return {1'b0, w};
	endfunction

endpackage

### design/mcwd_decode.sv
// ----------------------------------------------------------------------------
// Microcode control word lookup
// Combinational control store: boot copy sequence and running opcode decode,
// with the active-low lines inverted at the output.
// ----------------------------------------------------------------------------
module mcwd_decode
	import mcwd_pkg::*;
(
	input  logic [OP_W-1:0]   opcode,
	input  logic [STEP_W-1:0] step,
	input  logic [FLAG_W-1:0] flags,
	input  logic              copy_done,
	output logic [WORD_W-1:0] control_word
);

	function automatic lookup_t restore_tail(input logic last);
		if (!last) begin
			return hit(K_OEMEM | K_LDRL | cst(Q_RH | Q_NEG));
		end
		return hit(K_OEMEM | K_LDRH | cst(Q_MEM) | K_LDS);
	endfunction

	function automatic lookup_t rx_body(input logic [STEP_W-1:0] k, input logic c0);
		case (k)
			4'd1: return hit(K_OEALU | cst(Q_RL | Q_NEG));
			4'd2: return hit(K_OEALU | K_LDMEM | cst(Q_RH | Q_NEG));
			4'd3: return hit(K_OEALU | K_LDMEM);
			4'd4: return hit(K_OET | K_LDRL | K_LDRH | cst(Q_ADD));
			4'd5: return hit(K_OEALU | K_LDT | K_LDRH | cst(Q_FF));
			4'd6: return hit(K_OEALU | K_LDRL | cst(Q_UN));
			4'd7: return hit(K_GPI | K_LDTF);
			4'd8: return hit((c0 ? (K_OEALU | K_LDT) : K_OET) | cst(Q_RL | Q_NEG));
			4'd9: return restore_tail(1'b0);
			4'd10: return restore_tail(1'b1);
			default: return L_MISS;
		endcase
	endfunction

	function automatic lookup_t jump_word(input logic [STEP_W-1:0] st, input logic taken);
		if (taken) begin
			case (st)
				4'd1: return hit(K_OEMEM | K_LDT | K_INCR);
				4'd2: return hit(K_OEMEM | K_LDRL | K_INCR);
				4'd3: return hit(K_OET | K_LDRH | K_LDS);
				default: return L_MISS;
			endcase
		end
		case (st)
			4'd1: return hit(K_OET | K_INCR);
			4'd2: return hit(K_OET | K_INCR | K_LDS);
			default: return L_MISS;
		endcase
	endfunction

	function automatic lookup_t load_word(input logic [OP_W-1:0] op,
			input logic [STEP_W-1:0] st);
		logic ab;
		logic abs16;
		logic [STEP_W-1:0] k;
		ab = op[0];
		abs16 = !op[2];
		k = st;
		case (st)
			4'd1: return hit(K_OEMEM | K_LDT | K_INCR | cst(Q_RL | Q_NEG));
			4'd2: return hit(K_OEALU | K_LDMEM | cst(Q_RH | Q_NEG));
			4'd3: return abs16 ? hit(K_OEALU | K_LDMEM | cst(Q_MEM))
				: hit(K_OEALU | K_LDMEM);
			4'd4: return abs16 ? hit(K_OEMEM | K_LDRL)
				: hit(K_OET | K_LDRL | cst(Q_FF));
			4'd5: return hit((abs16 ? K_OET : K_OEALU) | K_LDRH | cst(Q_A | Q_NEG));
			4'd6: return hit(K_OEMEM | K_LDT | cst(Q_MEM));
			default: ;
		endcase
		if (ab) begin
			if (st == 4'd7) begin
				return hit(K_OET | K_LDMEM | cst(Q_B | Q_NEG));
			end
			if (st == 4'd8) begin
				return hit(K_OEMEM | K_LDT | (abs16 ? K_INCR : '0) | cst(Q_MEM));
			end
			k = st - 4'd2;
		end
		case (k)
			4'd7: return hit(K_OET | K_LDMEM | cst(Q_RL | Q_NEG));
			4'd8: return restore_tail(1'b0);
			4'd9: return abs16 ? hit(K_OEMEM | K_LDRH | cst(Q_MEM)) : restore_tail(1'b1);
			4'd10: return abs16 ? hit(K_OET | K_INCR | K_LDS) : L_MISS;
			default: return L_MISS;
		endcase
	endfunction

	function automatic lookup_t run_word(input logic [OP_W-1:0] op,
			input logic [STEP_W-1:0] st, input logic [FLAG_W-1:0] fl);
		logic c0;
		word_t ret;
		c0 = fl[0];
		ret = K_OEALU | cst(Q_MEM) | K_LDS;
		if (st == '0) begin
			return hit(K_FETCH);
		end
		case (op) inside
			OP_NOP: return hit(K_OET);
			OP_STORE: begin
				case (st)
					4'd1: return hit(K_OEMEM | K_LDT | K_INCR | cst(Q_A | Q_NEG));
					4'd2: return hit(K_OET | K_LDMEM | cst(Q_MEM) | K_LDS);
					default: return L_MISS;
				endcase
			end
			[OP_LDA_ABS:OP_LDB_IND]: return load_word(op, st);
			OP_TX_A, OP_TX_IMM, OP_TX_STOP: begin
				if (st == 4'd1 && op == OP_TX_A) begin
					return hit(K_OEMEM | cst(Q_A | Q_NEG));
				end
				if (st == 4'd1 && op == OP_TX_IMM) begin
					return hit(K_OEMEM | K_LDT | K_INCR);
				end
				if (st == 4'd2 && op == OP_TX_A) begin
					return hit(K_OEMEM | K_LDT);
				end
				if (st == 4'd7) begin
					return hit(K_OEALU | K_GPO
						| cst(op == OP_TX_STOP ? Q_GPO_IDLE : Q_GPO_LOW));
				end
				if (st == 4'd8) begin
					return hit(K_OEALU | cst(Q_MEM));
				end
				if (st == 4'd10) begin
					return hit(K_OEALU | K_LDS);
				end
				if (st <= 4'd9) begin
					return hit(K_OEALU);
				end
				return L_MISS;
			end
			OP_TX_MEM: begin
				case (st)
					4'd1: return hit(K_OEALU | cst(Q_RL | Q_NEG));
					4'd2: return hit(K_OEALU | K_LDMEM | cst(Q_RH | Q_NEG));
					4'd3: return hit(K_OEALU | K_LDMEM | cst(Q_FF));
					4'd4: return hit(K_OEALU | K_LDRL | cst(Q_UN));
					4'd5: return hit(K_OET | K_LDRH | K_INCR);
					4'd6: return hit(K_OEALU | K_LDTF | K_INCR);
					4'd7: return hit(K_OEALU | K_LDT | cst(Q_GPO_LOW | {3'b000, c0}) | K_GPO);
					4'd8: return hit(K_OEALU | cst(Q_RL | Q_NEG));
					4'd9: return restore_tail(1'b0);
					4'd10: return restore_tail(1'b1);
					default: return L_MISS;
				endcase
			end
			OP_TX_BREAK: begin
				case (st)
					4'd1: return hit(K_OEALU | cst(Q_GPO_BREAK) | K_GPO);
					4'd2, 4'd3: return hit(K_OEALU);
					4'd4: return hit(K_OEALU | cst(Q_GPO_IDLE) | K_GPO);
					4'd5: return hit(ret);
					default: return L_MISS;
				endcase
			end
			OP_RX_WAIT: begin
				if (st == 4'd1) begin
					return hit(K_GPI | K_LDTF);
				end
				if (st == 4'd15) begin
					return hit(ret);
				end
				return c0 ? hit(K_GPI | K_LDTF) : hit(ret);
			end
			OP_RX_FIRST: begin
				if (st == 4'd1) begin
					return hit(K_OEALU);
				end
				return rx_body(st - 4'd1, c0);
			end
			OP_RX_BIT: return rx_body(st, c0);
			OP_RX_LAST: begin
				if (st <= 4'd7) begin
					return rx_body(st, c0);
				end
				case (st)
					4'd8: return hit((c0 ? (K_OEALU | K_LDT) : K_OET) | cst(Q_FF));
					4'd9: return hit(K_OEALU | K_LDRL | K_LDRH | cst(Q_ADD));
					4'd10: return hit(K_OEALU | K_LDRL);
					4'd11: return hit(K_OET | K_LDRH | cst(Q_A | Q_NEG));
					4'd12: return hit(K_OEALU | K_LDMEM | cst(Q_RL | Q_NEG));
					4'd13: return restore_tail(1'b0);
					4'd14: return restore_tail(1'b1);
					default: return L_MISS;
				endcase
			end
			OP_INC: begin
				case (st)
					4'd1: return hit(K_OEALU | cst(Q_RL | Q_NEG));
					4'd2: return hit(K_OEALU | K_LDMEM | cst(Q_A | Q_NEG));
					4'd3: return hit(K_OEMEM | K_LDRL);
					4'd4: return hit(K_OEALU | K_INCR | cst(Q_RL));
					4'd5: return hit(K_OEALU | K_LDT | cst(Q_A | Q_NEG));
					4'd6: return hit(K_OET | K_LDMEM | cst(Q_RL | Q_NEG));
					4'd7: return hit(K_OEMEM | K_LDRL | cst(Q_MEM) | K_LDS);
					default: return L_MISS;
				endcase
			end
			OP_CMP: begin
				case (st)
					4'd1: return hit(K_OEMEM | K_LDT | K_INCR | cst(Q_RL | Q_NEG));
					4'd2: return hit(K_OEALU | K_LDMEM | cst(Q_RH | Q_NEG));
					4'd3: return hit(K_OEALU | K_LDMEM);
					4'd4: return hit(K_OET | K_LDRL | K_LDRH | cst(Q_NAND));
					4'd5: return hit(K_OEALU | K_LDRL | cst(Q_A | Q_NEG));
					4'd6: return hit(K_OEMEM | K_LDRH | K_INCR | cst(Q_ADDF));
					4'd7: return hit(K_OEALU | K_LDTF | cst(Q_RL | Q_NEG));
					4'd8: return restore_tail(1'b0);
					4'd9: return restore_tail(1'b1);
					default: return L_MISS;
				endcase
			end
			OP_JMP: return jump_word(st, 1'b1);
			OP_JC: return jump_word(st, c0);
			OP_JNZ: return jump_word(st, !fl[1]);
			default: return L_MISS;
		endcase
	endfunction

	function automatic word_t boot_word(input logic [STEP_W-1:0] st, input logic done);
		if (!done) begin
			return K_OEALU | K_LDMEM | K_INCR | K_LDS;
		end
		case (st)
			4'd0: return K_OEALU | cst(Q_GPO_IDLE) | K_GPO;
			4'd1: return K_OEALU | cst(Q_FF);
			4'd2: return K_OEALU | K_LDRH | K_LDRL;
			4'd3: return K_OEALU | K_LDTF | K_INCR | K_LDS;
			default: return K_OET | K_LDT;
		endcase
	endfunction

	lookup_t run_l;
	word_t   word_l;

	always_comb begin
		run_l = run_word(opcode, step, flags);
		if (!flags[3]) begin
			word_l = boot_word(step, copy_done);
		end else if (run_l[WORD_W]) begin
			word_l = (step == '0) ? K_FETCH : (K_OET | K_LDT);
		end else begin
			word_l = run_l[WORD_W-1:0];
		end
	end

	assign control_word = word_l ^ K_INVERT;

endmodule

### design/microcode_control_word_decoder.sv
// ----------------------------------------------------------------------------
// Microcode control word decoder
// Registers each request, looks up its control word and holds the result in
// an output register until it is taken.
// ----------------------------------------------------------------------------
// Each request passes from the input register to the output register, with
// the control store lookup between them. A new request is accepted every
// cycle as long as results are taken; when the output is stalled the input
// register still takes one more request before in_stall rises.
module microcode_control_word_decoder
	import mcwd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   opcode,
	input  logic [STEP_W-1:0] step,
	input  logic [FLAG_W-1:0] flags,
	input  logic              copy_done,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] control_word
);

	logic              valid_s1;
	logic [OP_W-1:0]   opcode_s1;
	logic [STEP_W-1:0] step_s1;
	logic [FLAG_W-1:0] flags_s1;
	logic              copy_done_s1;
	logic              valid_s2;
	logic [WORD_W-1:0] word_s2;
	logic [WORD_W-1:0] word_d;
	logic              adv_s2;
	logic              adv_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	mcwd_decode u_decode (
		.opcode       (opcode_s1),
		.step         (step_s1),
		.flags        (flags_s1),
		.copy_done    (copy_done_s1),
		.control_word (word_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			opcode_s1    <= opcode;
			step_s1      <= step;
			flags_s1     <= flags;
			copy_done_s1 <= copy_done;
		end
		if (adv_s2 && valid_s1) begin
			word_s2 <= word_d;
		end
	end

	assign out_valid    = valid_s2;
	assign control_word = word_s2;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while the pipeline has room");

	a_result_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> (out_valid && control_word == $past(word_d)))
		else $error("output register does not hold the looked-up word");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s1) |=> !out_valid)
		else $error("result repeated after it was taken");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(opcode_s1) && $stable(step_s1)
			&& $stable(flags_s1) && $stable(copy_done_s1)))
		else $error("input register changed while blocked");

endmodule
